### src/bleadv_pkg.sv
// ----------------------------------------------------------------------------
// BLE advertising framer package
// Shared constants, ROM tables and helper functions for the packet framer.
// ----------------------------------------------------------------------------
package bleadv_pkg;

   localparam int unsigned MAX_PAYLOAD = 24;

   localparam logic [23:0] CRC_PRESET = 24'h555555;
   localparam logic [23:0] CRC_POLY   = 24'h00065B;

   // Byte positions within the output of one transaction (header starts at 0,
   // mid-packet transactions start at the payload step).
   localparam logic [4:0] STEP_FIRST = 5'd0;
   localparam logic [4:0] STEP_PDU   = 5'd5;
   localparam logic [4:0] STEP_PAY   = 5'd20;
   localparam logic [4:0] STEP_CRC0  = 5'd21;
   localparam logic [4:0] STEP_LAST  = 5'd23;

   localparam int unsigned WHT_LEN = 42;

   localparam logic CSR_ADV_CHANNEL    = 1'b0;
   localparam logic CSR_PAYLOAD_LENGTH = 1'b1;

   localparam logic [1:0] ROW_CH37 = 2'd0;
   localparam logic [1:0] ROW_CH38 = 2'd1;
   localparam logic [1:0] ROW_CH39 = 2'd2;

   typedef struct packed {
      logic       vld;
      logic [4:0] step;
      logic [4:0] pos;
      logic [4:0] len;
      logic [7:0] data;
      logic       run_last;
      logic       pkt_end;
   } step_type;

   localparam logic [7:0] WHT_CH37 [WHT_LEN] = '{
      8'h8D, 8'hD2, 8'h57, 8'hA1, 8'h3D, 8'hA7, 8'h66, 8'hB0, 8'h75, 8'h31,
      8'h11, 8'h48, 8'h96, 8'h77, 8'hF8, 8'hE3, 8'h46, 8'hE9, 8'hAB, 8'hD0,
      8'h9E, 8'h53, 8'h33, 8'hD8, 8'hBA, 8'h98, 8'h08, 8'h24, 8'hCB, 8'h3B,
      8'hFC, 8'h71, 8'hA3, 8'hF4, 8'h55, 8'h68, 8'hCF, 8'hA9, 8'h19, 8'h6C,
      8'h5D, 8'h4C};

   localparam logic [7:0] WHT_CH38 [WHT_LEN] = '{
      8'hD6, 8'hC5, 8'h44, 8'h20, 8'h59, 8'hDE, 8'hE1, 8'h8F, 8'h1B, 8'hA5,
      8'hAF, 8'h42, 8'h7B, 8'h4E, 8'hCD, 8'h60, 8'hEB, 8'h62, 8'h22, 8'h90,
      8'h2C, 8'hEF, 8'hF0, 8'hC7, 8'h8D, 8'hD2, 8'h57, 8'hA1, 8'h3D, 8'hA7,
      8'h66, 8'hB0, 8'h75, 8'h31, 8'h11, 8'h48, 8'h96, 8'h77, 8'hF8, 8'hE3,
      8'h46, 8'hE9};

   localparam logic [7:0] WHT_CH39 [WHT_LEN] = '{
      8'h1F, 8'h37, 8'h4A, 8'h5F, 8'h85, 8'hF6, 8'h9C, 8'h9A, 8'hC1, 8'hD6,
      8'hC5, 8'h44, 8'h20, 8'h59, 8'hDE, 8'hE1, 8'h8F, 8'h1B, 8'hA5, 8'hAF,
      8'h42, 8'h7B, 8'h4E, 8'hCD, 8'h60, 8'hEB, 8'h62, 8'h22, 8'h90, 8'h2C,
      8'hEF, 8'hF0, 8'hC7, 8'h8D, 8'hD2, 8'h57, 8'hA1, 8'h3D, 8'hA7, 8'h66,
      8'hB0, 8'h75};

   function automatic logic [7:0] wht_byte(input logic [1:0] row, input logic [5:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (idx < 6'(WHT_LEN)) begin
         case (row)
            ROW_CH38: b = WHT_CH38[idx];
            ROW_CH39: b = WHT_CH39[idx];
            default:  b = WHT_CH37[idx];
         endcase
      end
      return b;
   endfunction

   // Fixed header with both length fields patched from the payload length.
   function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input logic [4:0] len);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'hAA;
         5'd1:    b = 8'hD6;
         5'd2:    b = 8'hBE;
         5'd3:    b = 8'h89;
         5'd4:    b = 8'h8E;
         5'd5:    b = 8'h42;
         5'd6:    b = 8'd13 + {3'b000, len};
         5'd7:    b = 8'h66;
         5'd8:    b = 8'h55;
         5'd9:    b = 8'h44;
         5'd10:   b = 8'h33;
         5'd11:   b = 8'h22;
         5'd12:   b = 8'h11;
         5'd13:   b = 8'h02;
         5'd14:   b = 8'h01;
         5'd15:   b = 8'h1A;
         5'd16:   b = 8'd3 + {3'b000, len};
         5'd17:   b = 8'hFF;
         5'd18:   b = 8'hF0;
         5'd19:   b = 8'hFF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // LSB-first CRC24 update over one byte.
   function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
      logic [23:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = b[k] ^ c[23];
         c  = {c[22:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic [23:0] rev24(input logic [23:0] v);
      logic [23:0] r;
      for (int k = 0; k < 24; k++) begin
         r[k] = v[23-k];
      end
      return r;
   endfunction

endpackage

### src/ble_adv_packet_framer.sv
// ----------------------------------------------------------------------------
// BLE advertising packet framer
// Frames payload bytes into whitened BLE advertising air bytes with CRC24.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one payload byte per transaction; rsp_* delivers air bytes,
//   one per transaction, with rsp_run_end on the last byte caused by a
//   payload byte and rsp_packet_end on the final CRC byte.
//   csr_* writes adv_channel (index 0) and payload_length (index 1); write
//   only while the block is idle.
//   The first air byte of a payload transaction reaches rsp through the
//   held-transaction register and then the output register.
//   Throughput: one air byte per cycle while rsp_ready is high. A payload
//   byte yields 1 air byte mid-packet, 21 at packet start (20-byte header),
//   4 at packet end (3 CRC bytes), 24 for a one-byte packet. The
//   single output byte per cycle sets this rate.
//   Reset: packet position cleared, CRC preset to 0x555555, channel 37,
//   payload length 8, no transaction held.
//   Stall: while rsp_ready is low the output register holds its byte, the
//   sequencer waits and, while a transaction is held, req_ready stays low
//   until that transaction's last byte enters the output register.
// ----------------------------------------------------------------------------
module ble_adv_packet_framer #(
   parameter int unsigned MaxPayload = bleadv_pkg::MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_air_byte,
   output logic       rsp_run_end,
   output logic       rsp_packet_end,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata
);

   logic [5:0] adv_channel_ff, adv_channel_in;
   logic [4:0] payload_length_ff, payload_length_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_air_byte_ff, rsp_air_byte_in;
   logic       rsp_run_end_ff, rsp_run_end_in;
   logic       rsp_packet_end_ff, rsp_packet_end_in;

   bleadv_pkg::step_type step;
   logic                 out_free;
   logic                 advance;
   logic [1:0]           row;
   logic [7:0]           air_byte;

   always_comb begin
      adv_channel_in    = adv_channel_ff;
      payload_length_in = payload_length_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bleadv_pkg::CSR_ADV_CHANNEL:    adv_channel_in = csr_wdata;
            bleadv_pkg::CSR_PAYLOAD_LENGTH: payload_length_in = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (adv_channel_ff)
         6'd38:   row = bleadv_pkg::ROW_CH38;
         6'd39:   row = bleadv_pkg::ROW_CH39;
         default: row = bleadv_pkg::ROW_CH37;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = step.vld && out_free;

   bleadv_seq #(
      .MaxPayload(MaxPayload)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .payload_length   (payload_length_ff),
      .advance          (advance),
      .step             (step)
   );

   bleadv_enc u_enc (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .advance  (advance),
      .row      (row),
      .air_byte (air_byte)
   );

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_air_byte_in   = rsp_air_byte_ff;
      rsp_run_end_in    = rsp_run_end_ff;
      rsp_packet_end_in = rsp_packet_end_ff;
      if (out_free) begin
         rsp_valid_in      = step.vld;
         rsp_air_byte_in   = air_byte;
         rsp_run_end_in    = step.run_last;
         rsp_packet_end_in = step.pkt_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_channel_ff    <= 6'd37;
         payload_length_ff <= 5'd8;
         rsp_valid_ff      <= 1'b0;
      end else begin
         adv_channel_ff    <= adv_channel_in;
         payload_length_ff <= payload_length_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_air_byte_ff   <= rsp_air_byte_in;
      rsp_run_end_ff    <= rsp_run_end_in;
      rsp_packet_end_ff <= rsp_packet_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_air_byte   = rsp_air_byte_ff;
   assign rsp_run_end    = rsp_run_end_ff;
   assign rsp_packet_end = rsp_packet_end_ff;

endmodule

### src/bleadv_seq.sv
// ----------------------------------------------------------------------------
// BLE advertising framer sequencer
// Holds the current transaction, steps through its output bytes and tracks
// the payload position within the packet.
// ----------------------------------------------------------------------------
module bleadv_seq #(
   parameter int unsigned MaxPayload = bleadv_pkg::MAX_PAYLOAD
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_payload_byte,
   input  logic [4:0]           payload_length,
   input  logic                 advance,
   output bleadv_pkg::step_type step
);

   logic       item_vld_ff, item_vld_in;
   logic [7:0] item_byte_ff, item_byte_in;
   logic [4:0] step_ff, step_in;
   logic [4:0] pos_ff, pos_in;

   logic [4:0] len_eff;
   logic [4:0] pos_inc;
   logic       end_pkt;
   logic       last;
   logic       fin;
   logic       accept;

   always_comb begin
      len_eff = payload_length;
      if (len_eff == 5'd0) begin
         len_eff = 5'd1;
      end
      if (len_eff > 5'(MaxPayload)) begin
         len_eff = 5'(MaxPayload);
      end
   end

   assign pos_inc   = pos_ff + 5'd1;
   assign end_pkt   = (pos_inc >= len_eff);
   assign last      = ((step_ff == bleadv_pkg::STEP_PAY) && !end_pkt) ||
                      (step_ff == bleadv_pkg::STEP_LAST);
   assign fin       = advance && last;
   assign req_ready = !item_vld_ff || fin;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pos_in       = pos_ff;
      item_vld_in  = item_vld_ff;
      item_byte_in = item_byte_ff;
      step_in      = step_ff;
      if (fin) begin
         pos_in = end_pkt ? 5'd0 : pos_inc;
      end
      if (accept) begin
         item_vld_in  = 1'b1;
         item_byte_in = req_payload_byte;
         step_in      = (pos_in == 5'd0) ? bleadv_pkg::STEP_FIRST : bleadv_pkg::STEP_PAY;
      end else if (fin) begin
         item_vld_in = 1'b0;
      end else if (advance) begin
         step_in = step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         step_ff     <= bleadv_pkg::STEP_FIRST;
         pos_ff      <= 5'd0;
      end else begin
         item_vld_ff <= item_vld_in;
         step_ff     <= step_in;
         pos_ff      <= pos_in;
      end
      item_byte_ff <= item_byte_in;
   end

   always_comb begin
      step.vld      = item_vld_ff;
      step.step     = step_ff;
      step.pos      = pos_ff;
      step.len      = len_eff;
      step.data     = item_byte_ff;
      step.run_last = last;
      step.pkt_end  = (step_ff == bleadv_pkg::STEP_LAST);
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < 5'(MaxPayload))
      else $error("payload position out of range");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff |-> (step_ff <= bleadv_pkg::STEP_LAST))
      else $error("step counter past last byte");

   a_hdr_at_start: assert property (@(posedge clock) disable iff (reset)
      (item_vld_ff && (step_ff < bleadv_pkg::STEP_PAY)) |-> (pos_ff == 5'd0))
      else $error("header emitted mid-packet");

endmodule

### src/bleadv_enc.sv
// ----------------------------------------------------------------------------
// BLE advertising framer byte encoder
// Selects header, payload or CRC byte, runs the CRC24 and applies whitening.
// ----------------------------------------------------------------------------
module bleadv_enc (
   input  logic                 clock,
   input  logic                 reset,
   input  bleadv_pkg::step_type step,
   input  logic                 advance,
   input  logic [1:0]           row,
   output logic [7:0]           air_byte
);

   logic [23:0] crc_ff, crc_in;
   logic [23:0] crc_rev;
   logic [7:0]  raw;
   logic [5:0]  widx;

   assign crc_rev = bleadv_pkg::rev24(crc_ff);
   assign widx    = {1'b0, step.pos} + {1'b0, step.step} - 6'd5;

   always_comb begin
      if (step.step < bleadv_pkg::STEP_PAY) begin
         raw = bleadv_pkg::hdr_byte(step.step, step.len);
      end else if (step.step == bleadv_pkg::STEP_PAY) begin
         raw = step.data;
      end else if (step.step == bleadv_pkg::STEP_CRC0) begin
         raw = crc_rev[7:0];
      end else if (step.step == bleadv_pkg::STEP_LAST) begin
         raw = crc_rev[23:16];
      end else begin
         raw = crc_rev[15:8];
      end
   end

   always_comb begin
      air_byte = raw;
      if (step.step >= bleadv_pkg::STEP_PDU) begin
         air_byte = raw ^ bleadv_pkg::wht_byte(row, widx);
      end
   end

   always_comb begin
      crc_in = crc_ff;
      if (advance) begin
         if ((step.step >= bleadv_pkg::STEP_PDU) && (step.step <= bleadv_pkg::STEP_PAY)) begin
            crc_in = bleadv_pkg::crc_feed(crc_ff, raw);
         end else if (step.step == bleadv_pkg::STEP_LAST) begin
            crc_in = bleadv_pkg::CRC_PRESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= bleadv_pkg::CRC_PRESET;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule
